// File: rtl/dclp_pkg.sv
// Shared types and constants for the draw command line parser.
// No dependencies; every other file of the block except dclp_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none
package dclp_pkg;

    localparam int LINE_CAP = 64;
    localparam int ADDR_W   = $clog2(LINE_CAP);
    localparam int LEN_W    = ADDR_W + 1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [15:0] MAX_COLOR = 16'd7;
    localparam logic [15:0] MAX_FONT  = 16'd2;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_TLINE  = 3'd1,
        KIND_FILL   = 3'd2,
        KIND_RECT   = 3'd3,
        KIND_BOX    = 3'd4,
        KIND_DTEXT  = 3'd5,
        KIND_TBYTE  = 3'd6,
        KIND_ERROR  = 3'd7
    } dclp_kind_t;

    localparam logic [4:0] ERR_EMPTY       = 5'd0;
    localparam logic [4:0] ERR_F_COLOR     = 5'd1;
    localparam logic [4:0] ERR_R_FEW       = 5'd2;
    localparam logic [4:0] ERR_R_FIELD     = 5'd3;
    localparam logic [4:0] ERR_R_COLOR     = 5'd4;
    localparam logic [4:0] ERR_B_FEW       = 5'd5;
    localparam logic [4:0] ERR_B_FIELD     = 5'd6;
    localparam logic [4:0] ERR_B_COLOR     = 5'd7;
    localparam logic [4:0] ERR_T_FEW       = 5'd8;
    localparam logic [4:0] ERR_T_FIELD     = 5'd9;
    localparam logic [4:0] ERR_T_COLOR     = 5'd10;
    localparam logic [4:0] ERR_T_FONT      = 5'd11;
    localparam logic [4:0] ERR_NO_COLON    = 5'd12;
    localparam logic [4:0] ERR_LINE_INDEX  = 5'd13;
    localparam logic [4:0] ERR_HDR_COLON   = 5'd14;
    localparam logic [4:0] ERR_HDR_COUNT   = 5'd15;
    localparam logic [4:0] ERR_HDR_FONT    = 5'd16;
    localparam logic [4:0] ERR_TL_COLON    = 5'd17;
    localparam logic [4:0] ERR_TL_COLOR    = 5'd18;
    localparam logic [4:0] ERR_OVERFLOW    = 5'd19;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_OVF,
        BK_SCAN_RD,
        BK_SCAN_USE,
        BK_CLASSIFY,
        BK_WALK_RD,
        BK_WALK_USE
    } dclp_bstate_t;

    typedef enum logic [2:0] {
        M_F,
        M_R,
        M_B,
        M_T,
        M_NUM
    } dclp_mode_t;

    typedef struct packed {
        logic             ovf;
        logic [LEN_W-1:0] len;
    } dclp_cmd_t;

    typedef struct packed {
        dclp_kind_t  kind;
        logic [15:0] index_or_count;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic [7:0]  thickness;
        logic [15:0] color;
        logic [7:0]  font;
        logic [7:0]  text_char;
        logic [4:0]  error_code;
        logic        last;
    } dclp_res_t;

endpackage
`default_nettype wire

// File: rtl/draw_command_line_parser_unit.sv
// Draw command line parser top level: front end, command queue, parser, line RAM.
// Depends on dclp_pkg, dclp_ram, dclp_queue, dclp_front and dclp_back.
// A word is taken while no line is being parsed and the command queue is not full.
// After an LF the parser first scans the stored bytes, then walks the fields; text words
// follow the line's result word. The input waits until the line is done.
// Reset clears all control state; the line RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module draw_command_line_parser_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // rx_byte
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // index_or_count, x1, y1, x2, y2, thickness, color, font, text_char,
    // error_code, zero padding
    output logic [127:0]       m_axis_tdata,
    output logic [2:0]         m_axis_tuser,   // kind
    output logic               m_axis_tlast    // last
);
    import dclp_pkg::*;

    dclp_cmd_t          push_cmd;
    dclp_cmd_t          head;
    dclp_res_t          res;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic               line_done;
    logic               parse_active;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;

    dclp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_cmd      (push_cmd),
        .queue_full    (q_full),
        .line_done     (line_done),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    dclp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    dclp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAP)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dclp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .queue_empty  (q_empty),
        .pop          (pop),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .line_done    (line_done),
        .parse_active (parse_active),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_res      (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {3'b000, res.error_code, res.text_char, res.font, res.color,
                           res.thickness, res.y2, res.x2, res.y1, res.x1,
                           res.index_or_count};

    a_no_write_while_parsing: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !parse_active)
        else $error("line buffer written while a line is parsed");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("command queue overrun");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_ERROR)) |-> m_axis_tlast)
        else $error("error word not marked last");

    a_done_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
        line_done |=> !parse_active)
        else $error("parser still active after line completion");

endmodule
`default_nettype wire

// File: rtl/dclp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/dclp_queue.sv
// Two-entry command queue between the byte front end and the line parser.
// Depends on dclp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dclp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dclp_pkg::dclp_cmd_t push_cmd,
    output logic                    full,
    input  wire logic               pop,
    output dclp_pkg::dclp_cmd_t     head,
    output logic                    empty
);
    import dclp_pkg::*;

    dclp_cmd_t   entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dclp_front.sv
// Byte front end: takes received words, fills the line buffer and queues commands.
// Depends on dclp_pkg; drives the write port of the line buffer RAM.
`timescale 1ns / 1ps
`default_nettype none
module dclp_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,
    output logic                             push,
    output dclp_pkg::dclp_cmd_t              push_cmd,
    input  wire logic                        queue_full,
    input  wire logic                        line_done,
    output logic                             wr_en,
    output logic [dclp_pkg::ADDR_W-1:0]      wr_addr,
    output logic [7:0]                       wr_data
);
    import dclp_pkg::*;

    logic [LEN_W-1:0] len_reg, len_next;
    logic             busy_reg, busy_next;
    logic             take;

    assign s_axis_tready = !busy_reg && !queue_full;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign wr_addr       = len_reg[ADDR_W-1:0];
    assign wr_data       = s_axis_tdata;

    always_comb
    begin
        len_next  = len_reg;
        busy_next = busy_reg;
        push      = 1'b0;
        push_cmd  = '{ovf: 1'b0, len: len_reg};
        wr_en     = 1'b0;
        if (line_done)
        begin
            busy_next = 1'b0;
        end
        if (take)
        begin
            priority if (s_axis_tdata == CH_CR)
            begin
                len_next = len_reg;
            end
            else if (s_axis_tdata == CH_LF)
            begin
                push      = 1'b1;
                len_next  = '0;
                busy_next = 1'b1;
            end
            else if ((len_reg + LEN_W'(1)) >= LEN_W'(LINE_CAP))
            begin
                push         = 1'b1;
                push_cmd.ovf = 1'b1;
                len_next     = '0;
            end
            else
            begin
                wr_en    = 1'b1;
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            busy_reg <= busy_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dclp_back.sv
// Line parser: scans a stored line, walks its fields and emits result words.
// Depends on dclp_pkg; drives the read port of the line buffer RAM.
`timescale 1ns / 1ps
`default_nettype none
module dclp_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dclp_pkg::dclp_cmd_t      head,
    input  wire logic                     queue_empty,
    output logic                          pop,
    output logic                          rd_en,
    output logic [dclp_pkg::ADDR_W-1:0]   rd_addr,
    input  wire logic [7:0]               rd_data,
    output logic                          line_done,
    output logic                          parse_active,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output dclp_pkg::dclp_res_t           out_res
);
    import dclp_pkg::*;

    dclp_bstate_t     state_reg, state_next;
    dclp_mode_t       mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic [LEN_W-1:0] c1_reg, c1_next;
    logic [LEN_W-1:0] cl_reg, cl_next;
    logic             has_colon_reg, has_colon_next;
    logic [7:0]       c0_reg, c0_next;
    logic [7:0]       b1_reg, b1_next;
    logic [2:0]       fi_reg, fi_next;
    logic [16:0]      acc_reg, acc_next;
    logic             nonempty_reg, nonempty_next;
    logic             bad_reg, bad_next;
    logic             text_reg, text_next;
    logic             end_reg, end_next;
    logic             hdr_reg, hdr_next;
    logic [15:0]      f_reg [5];
    logic             f_we;
    logic             out_valid_reg, out_valid_next;
    dclp_res_t        out_res_reg, out_res_next;

    logic             can_emit;
    logic             emit;
    dclp_res_t        res;
    logic             is_colon;
    logic             is_digit;
    logic             sep;
    logic             field_end;
    logic             ok;
    logic [15:0]      val;
    logic [20:0]      acc_mul;
    logic [LEN_W-1:0] pos_inc;
    logic             cmd_line;

    assign can_emit     = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_res      = out_res_reg;
    assign parse_active = (state_reg != BK_IDLE) && (state_reg != BK_OVF);
    assign pos_inc      = pos_reg + LEN_W'(1);
    assign rd_addr      = pos_reg[ADDR_W-1:0];

    assign is_colon  = !end_reg && (rd_data == CH_COLON);
    assign is_digit  = !end_reg && (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
    assign ok        = nonempty_reg && !bad_reg && !acc_reg[16];
    assign val       = acc_reg[15:0];
    assign acc_mul   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {17'd0, rd_data[3:0]};
    assign field_end = end_reg || (is_colon && sep);
    assign cmd_line  = ((c0_reg == CH_F) || (c0_reg == CH_R) || (c0_reg == CH_B)
                     || (c0_reg == CH_T)) && (n_reg > LEN_W'(1)) && (b1_reg == CH_COLON);

    always_comb
    begin
        unique case (mode_reg)
            M_F:
            begin
                sep = 1'b0;
            end
            M_R, M_B, M_T:
            begin
                sep = 1'b1;
            end
            default:
            begin
                if (fi_reg == 3'd0)
                begin
                    sep = 1'b1;
                end
                else if (hdr_reg)
                begin
                    sep = (fi_reg == 3'd1);
                end
                else
                begin
                    sep = (pos_reg == cl_reg);
                end
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        c1_next        = c1_reg;
        cl_next        = cl_reg;
        has_colon_next = has_colon_reg;
        c0_next        = c0_reg;
        b1_next        = b1_reg;
        fi_next        = fi_reg;
        acc_next       = acc_reg;
        nonempty_next  = nonempty_reg;
        bad_next       = bad_reg;
        text_next      = text_reg;
        end_next       = end_reg;
        hdr_next       = hdr_reg;
        f_we           = 1'b0;
        pop            = 1'b0;
        rd_en          = 1'b0;
        line_done      = 1'b0;
        emit           = 1'b0;
        res            = '0;
        res.last       = 1'b1;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop            = 1'b1;
                    len_next       = head.len;
                    pos_next       = '0;
                    has_colon_next = 1'b0;
                    state_next     = head.ovf ? BK_OVF : BK_SCAN_RD;
                end
            end
            BK_OVF:
            begin
                emit           = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_OVERFLOW;
                if (can_emit)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_SCAN_RD:
            begin
                if (pos_reg == len_reg)
                begin
                    n_next     = pos_reg;
                    state_next = BK_CLASSIFY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = BK_SCAN_USE;
                end
            end
            BK_SCAN_USE:
            begin
                if (rd_data == 8'd0)
                begin
                    n_next     = pos_reg;
                    state_next = BK_CLASSIFY;
                end
                else
                begin
                    if (pos_reg == LEN_W'(0))
                    begin
                        c0_next = rd_data;
                    end
                    if (pos_reg == LEN_W'(1))
                    begin
                        b1_next = rd_data;
                    end
                    if (rd_data == CH_COLON)
                    begin
                        if (!has_colon_reg)
                        begin
                            c1_next = pos_reg;
                        end
                        has_colon_next = 1'b1;
                        cl_next        = pos_reg;
                    end
                    pos_next   = pos_inc;
                    state_next = BK_SCAN_RD;
                end
            end
            BK_CLASSIFY:
            begin
                fi_next       = '0;
                acc_next      = '0;
                nonempty_next = 1'b0;
                bad_next      = 1'b0;
                text_next     = 1'b0;
                hdr_next      = 1'b0;
                priority if (n_reg == LEN_W'(0))
                begin
                    emit           = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_EMPTY;
                end
                else if (cmd_line)
                begin
                    pos_next   = LEN_W'(2);
                    state_next = BK_WALK_RD;
                    priority if (c0_reg == CH_F)
                    begin
                        mode_next = M_F;
                    end
                    else if (c0_reg == CH_R)
                    begin
                        mode_next = M_R;
                    end
                    else if (c0_reg == CH_B)
                    begin
                        mode_next = M_B;
                    end
                    else
                    begin
                        mode_next = M_T;
                    end
                end
                else if (!has_colon_reg)
                begin
                    emit           = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_NO_COLON;
                end
                else
                begin
                    pos_next   = '0;
                    mode_next  = M_NUM;
                    state_next = BK_WALK_RD;
                end
                if (emit)
                begin
                    if (can_emit)
                    begin
                        line_done  = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_CLASSIFY;
                    end
                end
            end
            BK_WALK_RD:
            begin
                end_next   = (pos_reg == n_reg);
                rd_en      = (pos_reg != n_reg);
                state_next = BK_WALK_USE;
            end
            default:
            begin
                if (text_reg)
                begin
                    emit          = 1'b1;
                    res.kind      = KIND_TBYTE;
                    res.text_char = rd_data;
                    res.last      = (pos_inc == n_reg);
                    if (can_emit)
                    begin
                        pos_next = pos_inc;
                        if (res.last)
                        begin
                            line_done  = 1'b1;
                            state_next = BK_IDLE;
                        end
                        else
                        begin
                            state_next = BK_WALK_RD;
                        end
                    end
                end
                else if (!field_end)
                begin
                    pos_next   = pos_inc;
                    state_next = BK_WALK_RD;
                    if (is_digit)
                    begin
                        nonempty_next = 1'b1;
                        acc_next = (acc_mul > 21'd65535) ? 17'd65536 : acc_mul[16:0];
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                else
                begin
                    res.kind = KIND_ERROR;
                    unique case (mode_reg)
                        M_F:
                        begin
                            emit = 1'b1;
                            if (!ok || (val > MAX_COLOR))
                            begin
                                res.error_code = ERR_F_COLOR;
                            end
                            else
                            begin
                                res.kind  = KIND_FILL;
                                res.color = val;
                            end
                        end
                        M_R:
                        begin
                            priority if (end_reg && (fi_reg < 3'd4))
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_R_FEW;
                            end
                            else if (!ok)
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_R_FIELD;
                            end
                            else if (fi_reg < 3'd4)
                            begin
                                f_we = 1'b1;
                            end
                            else if (val > MAX_COLOR)
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_R_COLOR;
                            end
                            else
                            begin
                                emit      = 1'b1;
                                res.kind  = KIND_RECT;
                                res.x1    = f_reg[0];
                                res.y1    = f_reg[1];
                                res.x2    = f_reg[2];
                                res.y2    = f_reg[3];
                                res.color = val;
                            end
                        end
                        M_B:
                        begin
                            priority if (end_reg && (fi_reg < 3'd5))
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_B_FEW;
                            end
                            else if (!ok)
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_B_FIELD;
                            end
                            else if (fi_reg < 3'd5)
                            begin
                                f_we = 1'b1;
                            end
                            else if (val > MAX_COLOR)
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_B_COLOR;
                            end
                            else
                            begin
                                emit          = 1'b1;
                                res.kind      = KIND_BOX;
                                res.x1        = f_reg[0];
                                res.y1        = f_reg[1];
                                res.x2        = f_reg[2];
                                res.y2        = f_reg[3];
                                res.thickness = f_reg[4][7:0];
                                res.color     = val;
                            end
                        end
                        M_T:
                        begin
                            priority if (end_reg)
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_T_FEW;
                            end
                            else if (!ok)
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_T_FIELD;
                            end
                            else if (fi_reg < 3'd3)
                            begin
                                f_we = 1'b1;
                            end
                            else if (f_reg[2] > MAX_COLOR)
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_T_COLOR;
                            end
                            else if (val > MAX_FONT)
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_T_FONT;
                            end
                            else
                            begin
                                emit      = 1'b1;
                                text_next = 1'b1;
                                res.kind  = KIND_DTEXT;
                                res.x1    = f_reg[0];
                                res.y1    = f_reg[1];
                                res.color = f_reg[2];
                                res.font  = val[7:0];
                                res.last  = (pos_inc == n_reg);
                            end
                        end
                        default:
                        begin
                            if (fi_reg == 3'd0)
                            begin
                                priority if (!ok)
                                begin
                                    emit           = 1'b1;
                                    res.error_code = ERR_LINE_INDEX;
                                end
                                else if ((val != 16'd0) && (cl_reg == c1_reg))
                                begin
                                    emit           = 1'b1;
                                    res.error_code = ERR_TL_COLON;
                                end
                                else
                                begin
                                    f_we     = 1'b1;
                                    hdr_next = (val == 16'd0);
                                end
                            end
                            else if (hdr_reg)
                            begin
                                priority if (fi_reg == 3'd1 && end_reg)
                                begin
                                    emit           = 1'b1;
                                    res.error_code = ERR_HDR_COLON;
                                end
                                else if (fi_reg == 3'd1 && !ok)
                                begin
                                    emit           = 1'b1;
                                    res.error_code = ERR_HDR_COUNT;
                                end
                                else if (fi_reg == 3'd1)
                                begin
                                    f_we = 1'b1;
                                end
                                else if (!ok)
                                begin
                                    emit           = 1'b1;
                                    res.error_code = ERR_HDR_FONT;
                                end
                                else
                                begin
                                    emit               = 1'b1;
                                    res.kind           = KIND_HEADER;
                                    res.index_or_count = f_reg[1];
                                    res.font           = val[7:0];
                                end
                            end
                            else if (!ok)
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_TL_COLOR;
                            end
                            else
                            begin
                                emit               = 1'b1;
                                text_next          = 1'b1;
                                res.kind           = KIND_TLINE;
                                res.index_or_count = f_reg[0];
                                res.color          = val;
                                res.last           = (pos_inc == n_reg);
                            end
                        end
                    endcase

                    if (f_we)
                    begin
                        fi_next       = fi_reg + 3'd1;
                        acc_next      = '0;
                        nonempty_next = 1'b0;
                        bad_next      = 1'b0;
                        pos_next      = pos_inc;
                        state_next    = BK_WALK_RD;
                    end
                    else if (can_emit)
                    begin
                        pos_next = pos_inc;
                        if (res.last)
                        begin
                            line_done  = 1'b1;
                            state_next = BK_IDLE;
                        end
                        else
                        begin
                            state_next = BK_WALK_RD;
                        end
                    end
                    else
                    begin
                        text_next = 1'b0;
                    end
                end
            end
        endcase

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (emit && can_emit)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            text_reg      <= 1'b0;
            end_reg       <= 1'b0;
            hdr_reg       <= 1'b0;
            mode_reg      <= M_F;
            fi_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            text_reg      <= text_next;
            end_reg       <= end_next;
            hdr_reg       <= hdr_next;
            mode_reg      <= mode_next;
            fi_reg        <= fi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        pos_reg       <= pos_next;
        n_reg         <= n_next;
        c1_reg        <= c1_next;
        cl_reg        <= cl_next;
        has_colon_reg <= has_colon_next;
        c0_reg        <= c0_next;
        b1_reg        <= b1_next;
        acc_reg       <= acc_next;
        nonempty_reg  <= nonempty_next;
        bad_reg       <= bad_next;
        out_res_reg   <= out_res_next;
        if (f_we && (fi_reg < 3'd5))
        begin
            f_reg[fi_reg] <= val;
        end
    end

endmodule
`default_nettype wire
